// ===== rtl/assert_macros.svh =====
// Assertion macros for the great-circle distance checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define GCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that must hold at every clock edge, reset included.
`define GCD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/gcd_pkg.sv =====
// Package for the great-circle distance block: widths, fixed-point constants and
// the arctangent step function. No dependencies.
`timescale 1ns / 1ps
package gcd_pkg;
    localparam int AngleFracBits = 30;
    localparam int CordicSteps   = 32;
    localparam int FullTurn      = 1296000;
    localparam int HalfTurn      = 648000;
    localparam int QuarterTurn   = 324000;
    localparam int DistMax       = 2001512;
    localparam int RadiusCentikm = 637101;
    localparam logic [63:0] PiQ62   = 64'hC90FDAA22168C235;
    localparam logic [63:0] GainQ62 = 64'd2800459870029452900;
    localparam logic [63:0] ArcsecRadQ62 = (PiQ62 + 64'd324000) / 64'd648000;

    typedef struct packed {
        logic [6:0]  lat1_deg;
        logic [5:0]  lat1_min;
        logic [5:0]  lat1_sec;
        logic        lat1_south;
        logic [7:0]  lon1_deg;
        logic [5:0]  lon1_min;
        logic [5:0]  lon1_sec;
        logic        lon1_west;
        logic [6:0]  lat2_deg;
        logic [11:0] lat2_min_sec;
        logic [19:0] lon2_deg_min_sec;
        logic [1:0]  point2_hemis;
    } in_item_t;

    typedef struct packed {
        logic [20:0] distance_centikm;
    } out_item_t;

    // Q62 value rounded half up to f fraction bits.
    function automatic logic [63:0] from_q62(input logic [63:0] v, input int f);
        logic [63:0] half;
        half = 64'd1 << (61 - f);
        return (v + half) >> (62 - f);
    endfunction

    // atan(2^-i) at f fraction bits, from the alternating series in Q62.
    function automatic logic [63:0] atan_fix(input int i, input int f);
        logic signed [63:0] sum;
        logic [63:0] v;
        bit plus;
        sum = 0;
        plus = 1'b1;
        if (i == 0)
        begin
            v = PiQ62 >> 2;
        end
        else
        begin
            for (int k = 1; i * k <= 62; k += 2)
            begin
                if (plus)
                    sum = sum + signed'((64'd1 << (62 - i * k)) / 64'(k));
                else
                    sum = sum - signed'((64'd1 << (62 - i * k)) / 64'(k));
                plus = !plus;
            end
            v = 64'(sum);
        end
        return from_q62(v, f);
    endfunction
endpackage

// ===== rtl/gcd_if.sv =====
// Valid/ready channel interface carrying one item.
// No dependencies.
`timescale 1ns / 1ps
interface gcd_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gcd_trig.sv =====
// Pipelined rotation CORDIC lane: angle in arc seconds plus sign to cos and sin.
// Depends on gcd_pkg. One item a cycle while en is high.
`timescale 1ns / 1ps
module gcd_trig #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::AngleFracBits,
    parameter int CORDIC_STEPS    = gcd_pkg::CordicSteps
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [20:0]                  total,
    input  logic                         neg,
    output logic signed [ANGLE_FRAC_BITS+2:0] cos_out,
    output logic signed [ANGLE_FRAC_BITS+2:0] sin_out
);
    localparam int W = ANGLE_FRAC_BITS + 3;
    localparam int S = 62 - ANGLE_FRAC_BITS;
    localparam logic [63:0] Gain = gcd_pkg::from_q62(gcd_pkg::GainQ62, ANGLE_FRAC_BITS);

    // stage A: wrap and fold into [-90, 90] degrees
    logic signed [21:0] a_reg;
    logic               flip_a_reg;
    logic signed [21:0] a_next, w;
    logic               flip_next;
    logic [20:0]        red;

    always_comb
    begin
        red = (total >= 21'(gcd_pkg::FullTurn)) ? total - 21'(gcd_pkg::FullTurn) : total;
        w = (red >= 21'(gcd_pkg::HalfTurn)) ? 22'(red) - 22'(gcd_pkg::FullTurn) : 22'(red);
        if (neg)
            w = -w;
        flip_next = 1'b0;
        a_next = w;
        if (w > 22'(gcd_pkg::QuarterTurn))
        begin
            a_next = 22'(gcd_pkg::HalfTurn) - w;
            flip_next = 1'b1;
        end
        else if (w < -22'(gcd_pkg::QuarterTurn))
        begin
            a_next = -22'(gcd_pkg::HalfTurn) - w;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            flip_a_reg <= flip_next;
        end
    end

    // stage B: arc seconds to radians (19-bit by 64-bit constant)
    logic [18:0]  mag;
    logic [82:0]  prod;
    logic signed [W-1:0] z0_reg, z0_next;
    logic         flip_b_reg;

    always_comb
    begin
        mag = a_reg[21] ? 19'(-a_reg) : 19'(a_reg);
        prod = 83'(mag) * 83'(gcd_pkg::ArcsecRadQ62) + (83'(1) << (S - 1));
        z0_next = a_reg[21] ? -W'(prod >> S) : W'(prod >> S);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg <= z0_next;
            flip_b_reg <= flip_a_reg;
        end
    end

    logic signed [W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [W-1:0] z_reg [CORDIC_STEPS+1];
    logic                f_reg [CORDIC_STEPS+1];

    assign x_reg[0] = W'(Gain);
    assign y_reg[0] = '0;
    assign z_reg[0] = z0_reg;
    assign f_reg[0] = flip_b_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [W-1:0] T = W'(gcd_pkg::atan_fix(i, ANGLE_FRAC_BITS));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - T;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + T;
                end
                f_reg[i+1] <= f_reg[i];
            end
        end
    end

    assign cos_out = f_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign sin_out = y_reg[CORDIC_STEPS];
endmodule

// ===== rtl/gcd_merge.sv =====
// Merge stage: unit vectors, dot product, arccosine and scaling to 0.01 km.
// Depends on gcd_pkg. Pipelined, one item a cycle while en is high.
`timescale 1ns / 1ps
module gcd_merge #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::AngleFracBits,
    parameter int CORDIC_STEPS    = gcd_pkg::CordicSteps
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ANGLE_FRAC_BITS+2:0] clat1,
    input  logic signed [ANGLE_FRAC_BITS+2:0] slat1,
    input  logic signed [ANGLE_FRAC_BITS+2:0] clon1,
    input  logic signed [ANGLE_FRAC_BITS+2:0] slon1,
    input  logic signed [ANGLE_FRAC_BITS+2:0] clat2,
    input  logic signed [ANGLE_FRAC_BITS+2:0] slat2,
    input  logic signed [ANGLE_FRAC_BITS+2:0] clon2,
    input  logic signed [ANGLE_FRAC_BITS+2:0] slon2,
    output logic [20:0]                       distance
);
    localparam int F = ANGLE_FRAC_BITS;
    localparam int W = F + 3;
    localparam int PW = 2 * W;
    localparam int QW = 2 * F + 2;
    localparam int SQ_STEPS = F + 1;
    localparam logic [63:0] PiF = gcd_pkg::from_q62(gcd_pkg::PiQ62, F);
    localparam logic signed [W-1:0] OneF = W'(1) << F;

    // product rounded half away from zero to F bits
    function automatic logic signed [W+1:0] rmul(input logic signed [PW-1:0] p);
        logic [PW-1:0] m;
        m = p[PW-1] ? PW'(-p) : PW'(p);
        m = (m + (PW'(1) << (F - 1))) >> F;
        return p[PW-1] ? -(W+2)'(m) : (W+2)'(m);
    endfunction

    logic signed [PW-1:0] p0_reg, p1_reg, p0_next, p1_next;
    logic signed [W-1:0]  z1_reg, z2_reg [2], z2_next;
    logic signed [W-1:0]  v0_reg, v1_reg, q0_reg, q1_reg;
    logic signed [PW-1:0] p2_reg, p3_reg, q2p_reg;
    logic signed [PW-1:0] m0_reg, m1_reg, m2_reg;
    logic signed [W-1:0]  z1s_reg;
    logic signed [W+3:0]  dot_reg;

    // stage 1: lane products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= PW'(clat1) * PW'(clon1);
            p1_reg <= PW'(clat1) * PW'(slon1);
            p2_reg <= PW'(clat2) * PW'(clon2);
            p3_reg <= PW'(clat2) * PW'(slon2);
            z1_reg <= slat1;
            z2_reg[0] <= slat2;
        end
    end
    assign p0_next = p0_reg;
    assign p1_next = p1_reg;
    assign z2_next = z2_reg[0];

    // stage 2: round to vector components
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg <= W'(rmul(p0_next));
            v1_reg <= W'(rmul(p1_next));
            q0_reg <= W'(rmul(p2_reg));
            q1_reg <= W'(rmul(p3_reg));
            z1s_reg <= z1_reg;
            z2_reg[1] <= z2_next;
        end
    end

    // stage 3: dot product partials
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg <= PW'(v0_reg) * PW'(q0_reg);
            m1_reg <= PW'(v1_reg) * PW'(q1_reg);
            m2_reg <= PW'(z1s_reg) * PW'(z2_reg[1]);
        end
    end
    assign q2p_reg = m2_reg;

    // stage 4: sum
    always_ff @(posedge clk)
    begin
        if (en)
            dot_reg <= (W+4)'(rmul(m0_reg)) + (W+4)'(rmul(m1_reg)) + (W+4)'(rmul(q2p_reg));
    end

    // stage 5: saturate the dot product to [-1, 1]
    logic signed [W-1:0] c_reg, c_next;
    always_comb
    begin
        if (dot_reg > (W+4)'(OneF))
            c_next = OneF;
        else if (dot_reg < -(W+4)'(OneF))
            c_next = -OneF;
        else
            c_next = W'(dot_reg);
    end
    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    // stage 6: (1-c)(1+c), both in [0, 2]
    logic [QW+1:0] sq_reg;
    logic signed [W-1:0] c6_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= (QW+2)'(F'(0) | (OneF - c_reg)) * (QW+2)'(OneF + c_reg);
            c6_reg <= c_reg;
        end
    end

    // square root, one result bit per stage
    localparam int RW = F + 2;
    logic [QW+1:0]  sr_v  [SQ_STEPS+1];
    logic [RW+1:0]  sr_rem [SQ_STEPS+1];
    logic [RW-1:0]  sr_root [SQ_STEPS+1];
    logic signed [W-1:0] sr_c [SQ_STEPS+1];
    assign sr_v[0] = sq_reg;
    assign sr_rem[0] = '0;
    assign sr_root[0] = '0;
    assign sr_c[0] = c6_reg;
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - k;
        logic [RW+1:0] rem_t, trial;
        always_comb
        begin
            rem_t = (RW+2)'({sr_rem[k], sr_v[k][2*B+1 -: 2]});
            trial = (RW+2)'({sr_root[k], 2'b01});
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_v[k+1] <= sr_v[k];
                sr_c[k+1] <= sr_c[k];
                if (rem_t >= trial)
                begin
                    sr_rem[k+1] <= rem_t - trial;
                    sr_root[k+1] <= (RW)'({sr_root[k], 1'b1});
                end
                else
                begin
                    sr_rem[k+1] <= rem_t;
                    sr_root[k+1] <= (RW)'({sr_root[k], 1'b0});
                end
            end
        end
    end

    // vectoring CORDIC
    logic signed [W-1:0] ax [CORDIC_STEPS+1];
    logic signed [W-1:0] ay [CORDIC_STEPS+1];
    logic signed [W-1:0] az [CORDIC_STEPS+1];
    logic                an [CORDIC_STEPS+1];
    logic signed [W-1:0] cs;
    assign cs = sr_c[SQ_STEPS];
    assign ax[0] = cs[W-1] ? -cs : cs;
    assign ay[0] = W'(sr_root[SQ_STEPS]);
    assign az[0] = '0;
    assign an[0] = cs[W-1];
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        localparam logic signed [W-1:0] T = W'(gcd_pkg::atan_fix(i, F));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ay[i] >= 0)
                begin
                    ax[i+1] <= ax[i] + (ay[i] >>> i);
                    ay[i+1] <= ay[i] - (ax[i] >>> i);
                    az[i+1] <= az[i] + T;
                end
                else
                begin
                    ax[i+1] <= ax[i] - (ay[i] >>> i);
                    ay[i+1] <= ay[i] + (ax[i] >>> i);
                    az[i+1] <= az[i] - T;
                end
                an[i+1] <= an[i];
            end
        end
    end

    // fold to [0, pi]
    logic signed [W-1:0] za, zb, ang_reg;
    always_comb
    begin
        za = az[CORDIC_STEPS] < 0 ? '0 : az[CORDIC_STEPS];
        zb = an[CORDIC_STEPS] ? W'(PiF) - za : za;
        if (zb < 0)
            zb = '0;
        if (zb > W'(PiF))
            zb = W'(PiF);
    end
    always_ff @(posedge clk)
    begin
        if (en)
            ang_reg <= zb;
    end

    // scale by radius, round half up, saturate
    localparam int DW = W + 20;
    logic [DW-1:0] dprod_reg;
    logic [DW-1:0] dr;
    always_ff @(posedge clk)
    begin
        if (en)
            dprod_reg <= DW'(unsigned'(ang_reg)) * DW'(gcd_pkg::RadiusCentikm);
    end
    always_comb
        dr = (dprod_reg + (DW'(1) << (F - 1))) >> F;
    assign distance = (dr > DW'(gcd_pkg::DistMax)) ? 21'(gcd_pkg::DistMax) : 21'(dr);
endmodule

// ===== rtl/great_circle_distance.sv =====
// Great-circle distance, spherical law of cosines, in fixed point.
// Depends on gcd_pkg, gcd_if, gcd_trig, gcd_merge.
// The result passes through the trig lanes, vector and dot product, square root,
//   arccos and scaling.
// Throughput: one item per cycle; the whole datapath stalls only when the output register is full and not taken.
// Reset clears the valid pipeline and the output valid flag; data registers are not reset.
`timescale 1ns / 1ps
module great_circle_distance #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::AngleFracBits,
    parameter int CORDIC_STEPS    = gcd_pkg::CordicSteps
) (
    input  logic clk,
    input  logic rst_n,
    gcd_if.sink   in_ch,
    gcd_if.source out_ch
);
    localparam int W = ANGLE_FRAC_BITS + 3;
    // trig lanes CORDIC_STEPS + 2, merge front 6, square root ANGLE_FRAC_BITS + 1,
    // arccos CORDIC_STEPS, angle and scaling 2
    localparam int LAT = CORDIC_STEPS + 2 + 6 + ANGLE_FRAC_BITS + 1 + CORDIC_STEPS + 2;

    gcd_pkg::in_item_t it;
    logic en;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg;
    logic [20:0] out_data_reg;
    logic [20:0] distance;

    // Whole pipe advances when the output register is free or being taken.
    assign en = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;
    assign it = in_ch.data;

    // Angles in arc seconds for the four lanes.
    logic [20:0] lat1, lon1, lat2, lon2;
    always_comb
    begin
        lat1 = 21'(it.lat1_deg) * 21'd3600 + 21'(it.lat1_min) * 21'd60 + 21'(it.lat1_sec);
        lon1 = 21'(it.lon1_deg) * 21'd3600 + 21'(it.lon1_min) * 21'd60 + 21'(it.lon1_sec);
        lat2 = 21'(it.lat2_deg) * 21'd3600 + 21'(it.lat2_min_sec);
        lon2 = 21'(it.lon2_deg_min_sec);
    end

    logic signed [W-1:0] clat1, slat1, clon1, slon1, clat2, slat2, clon2, slon2;

    gcd_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lat1 (
        .clk(clk), .en(en), .total(lat1), .neg(it.lat1_south),
        .cos_out(clat1), .sin_out(slat1));
    gcd_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lon1 (
        .clk(clk), .en(en), .total(lon1), .neg(it.lon1_west),
        .cos_out(clon1), .sin_out(slon1));
    gcd_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lat2 (
        .clk(clk), .en(en), .total(lat2), .neg(it.point2_hemis[0]),
        .cos_out(clat2), .sin_out(slat2));
    gcd_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lon2 (
        .clk(clk), .en(en), .total(lon2), .neg(it.point2_hemis[1]),
        .cos_out(clon2), .sin_out(slon2));

    gcd_merge #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_merge (
        .clk(clk), .en(en),
        .clat1(clat1), .slat1(slat1), .clon1(clon1), .slon1(slon1),
        .clat2(clat2), .slat2(slat2), .clon2(clon2), .slon2(slon2),
        .distance(distance));

    // valid tracking alongside the data pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= LAT'({vld_reg[LAT-2:0], in_ch.valid});
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= distance;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data.distance_centikm = out_data_reg;
endmodule

// ===== rtl/gcd_checker.sv =====
// Port-level checker for great_circle_distance, bound to the top level.
// Depends on gcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gcd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [20:0] out_dist
);
    `GCD_ASSERT(a_range, clk, rst_n, out_valid |-> out_dist <= 21'(gcd_pkg::DistMax), "distance out of range")
    `GCD_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_dist), "result dropped")
    `GCD_ASSERT(a_ready, clk, rst_n, !out_valid |-> in_ready, "stalled with empty output")
    `GCD_ASSERT_ALWAYS(a_rst, clk, !rst_n |-> !out_valid, "valid during reset")
endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_dist(out_ch.data.distance_centikm));

// ===== tb/sv/great_circle_distance_tb.sv =====
// Self-checking testbench for great_circle_distance: drives coordinate pairs
// and checks each distance against its own fixed-point prediction.
// Depends on gcd_pkg, gcd_if and the great_circle_distance RTL.
`timescale 1ns / 1ps
module great_circle_distance_tb;
    localparam int    ItemCount   = 2000;
    localparam int    DrainCycles = 150;
    localparam int    CycleLimit  = 500000;
    localparam int    InBits      = $bits(gcd_pkg::in_item_t);
    localparam longint OneF       = 64'sd1 << gcd_pkg::AngleFracBits;

    logic clk;
    logic rst_n;

    gcd_if #(.T(gcd_pkg::in_item_t))  in_ch  ();
    gcd_if #(.T(gcd_pkg::out_item_t)) out_ch ();

    great_circle_distance dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // ------------------------------------------------------------------
    // Distance predictor
    // ------------------------------------------------------------------
    longint arctan_tab [gcd_pkg::CordicSteps];

    // Q62 constant rounded half up to the angle format.
    function automatic longint q62_round(longint unsigned v);
        return longint'((v + (64'd1 << (61 - gcd_pkg::AngleFracBits)))
                        >> (62 - gcd_pkg::AngleFracBits));
    endfunction

    // atan(2^-i) built from its power series in Q62.
    function automatic longint arctan_step(int i);
        longint acc;
        bit     add;
        acc = 0;
        add = 1'b1;
        if (i == 0)
            return q62_round(gcd_pkg::PiQ62 >> 2);
        for (int k = 1; i * k <= 62; k += 2)
        begin
            if (add)
                acc += longint'((64'd1 << (62 - i * k)) / longint'(k));
            else
                acc -= longint'((64'd1 << (62 - i * k)) / longint'(k));
            add = !add;
        end
        return q62_round(longint'(acc));
    endfunction

    function automatic longint arcsec_to_rad(longint unsigned arcsec);
        longint unsigned p;
        p = arcsec * gcd_pkg::ArcsecRadQ62 + (64'd1 << (61 - gcd_pkg::AngleFracBits));
        return longint'(p >> (62 - gcd_pkg::AngleFracBits));
    endfunction

    // Signed product, rounded half away from zero.
    function automatic longint fix_mul(longint a, longint b);
        logic [127:0]    prod;
        longint unsigned ua, ub, r;
        ua   = (a < 0) ? longint'(-a) : a;
        ub   = (b < 0) ? longint'(-b) : b;
        prod = 128'(ua) * 128'(ub) + (128'd1 << (gcd_pkg::AngleFracBits - 1));
        r    = 64'(prod >> gcd_pkg::AngleFracBits);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Rotation CORDIC: cosine and sine of an angle in arc seconds.
    function automatic void sin_cos(longint unsigned total, bit neg,
                                    output longint c, output longint s);
        longint a, x, y, z, dx, dy;
        bit     mirror;
        a      = longint'(total % gcd_pkg::FullTurn);
        mirror = 1'b0;
        if (a >= gcd_pkg::HalfTurn)
            a -= gcd_pkg::FullTurn;
        if (neg)
            a = -a;
        // fold into [-90, 90] degrees; cosine changes sign
        if (a > gcd_pkg::QuarterTurn)
        begin
            a = gcd_pkg::HalfTurn - a;
            mirror = 1'b1;
        end
        else if (a < -gcd_pkg::QuarterTurn)
        begin
            a = -gcd_pkg::HalfTurn - a;
            mirror = 1'b1;
        end
        z = (a >= 0) ? arcsec_to_rad(a) : -arcsec_to_rad(-a);
        x = q62_round(gcd_pkg::GainQ62);
        y = 0;
        for (int i = 0; i < gcd_pkg::CordicSteps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan_tab[i];
            end
        end
        c = mirror ? -x : x;
        s = y;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root, t;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if (t * t <= n)
                root = t;
        end
        return longint'(root);
    endfunction

    // Vectoring CORDIC arccosine, result in [0, pi].
    function automatic longint arc_cos(longint c);
        longint pi_f, x, y, z, dx, dy;
        pi_f = q62_round(gcd_pkg::PiQ62);
        if (c > OneF)
            c = OneF;
        if (c < -OneF)
            c = -OneF;
        y = int_sqrt(longint'(OneF - c) * longint'(OneF + c));
        x = (c < 0) ? -c : c;
        z = 0;
        for (int i = 0; i < gcd_pkg::CordicSteps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arctan_tab[i];
            end
            else
            begin
                x -= dx; y += dy; z -= arctan_tab[i];
            end
        end
        if (z < 0)
            z = 0;
        if (c < 0)
            z = pi_f - z;
        if (z < 0)
            z = 0;
        if (z > pi_f)
            z = pi_f;
        return z;
    endfunction

    function automatic void to_vector(longint unsigned lat, bit south,
                                      longint unsigned lon, bit west,
                                      output longint vx, output longint vy,
                                      output longint vz);
        longint clat, slat, clon, slon;
        sin_cos(lat, south, clat, slat);
        sin_cos(lon, west, clon, slon);
        vx = fix_mul(clat, clon);
        vy = fix_mul(clat, slon);
        vz = slat;
    endfunction

    function automatic gcd_pkg::out_item_t predict_distance(gcd_pkg::in_item_t it);
        longint unsigned lat1, lon1, lat2, lon2, d;
        longint px, py, pz, qx, qy, qz, dot, ang;
        gcd_pkg::out_item_t r;
        lat1 = it.lat1_deg * 3600 + it.lat1_min * 60 + it.lat1_sec;
        lon1 = it.lon1_deg * 3600 + it.lon1_min * 60 + it.lon1_sec;
        lat2 = it.lat2_deg * 3600 + it.lat2_min_sec;
        lon2 = it.lon2_deg_min_sec;
        to_vector(lat1, it.lat1_south, lon1, it.lon1_west, px, py, pz);
        to_vector(lat2, it.point2_hemis[0], lon2, it.point2_hemis[1], qx, qy, qz);
        dot = fix_mul(px, qx) + fix_mul(py, qy) + fix_mul(pz, qz);
        ang = arc_cos(dot);
        d   = (longint'(ang) * gcd_pkg::RadiusCentikm
               + (64'd1 << (gcd_pkg::AngleFracBits - 1))) >> gcd_pkg::AngleFracBits;
        if (d > gcd_pkg::DistMax)
            d = gcd_pkg::DistMax;
        r.distance_centikm = d[20:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: expected distances in arrival order
    // ------------------------------------------------------------------
    class distance_board;
        gcd_pkg::out_item_t pending[$];
        int        errors;
        int        checked;

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void note_input(gcd_pkg::out_item_t expected);
            pending.push_back(expected);
        endfunction

        task check_result(gcd_pkg::out_item_t got);
            gcd_pkg::out_item_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected distance %0d", got.distance_centikm));
                return;
            end
            want = pending.pop_front();
            if (got.distance_centikm !== want.distance_centikm)
                report($sformatf("distance_centikm got %0d want %0d (result %0d)",
                                 got.distance_centikm, want.distance_centikm, checked));
        endtask
    endclass

    distance_board board;

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    int cycle_count;
    bit hold_output;        // long receiver stall, to back the pipe up

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("great_circle_distance_tb NOT OK");
            $finish;
        end
    end

    // Both channels are sampled at the edge; our drives land after it.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_input(predict_distance(in_ch.data));
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.data);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic gcd_pkg::in_item_t make_pair(int a_d, int a_m, int a_s, int a_s_flag,
                                                    int o_d, int o_m, int o_s, int o_w_flag,
                                                    int b_d, int b_ms, int b_lon, int hemis);
        gcd_pkg::in_item_t it;
        it.lat1_deg         = 7'(a_d);
        it.lat1_min         = 6'(a_m);
        it.lat1_sec         = 6'(a_s);
        it.lat1_south       = 1'(a_s_flag);
        it.lon1_deg         = 8'(o_d);
        it.lon1_min         = 6'(o_m);
        it.lon1_sec         = 6'(o_s);
        it.lon1_west        = 1'(o_w_flag);
        it.lat2_deg         = 7'(b_d);
        it.lat2_min_sec     = 12'(b_ms);
        it.lon2_deg_min_sec = 20'(b_lon);
        it.point2_hemis     = 2'(hemis);
        return it;
    endfunction

    function automatic gcd_pkg::in_item_t random_pair();
        gcd_pkg::in_item_t it;
        if ($urandom_range(0, 9) < 8)
            // well-formed positions
            it = make_pair($urandom_range(0, 90), $urandom_range(0, 59),
                           $urandom_range(0, 59), $urandom_range(0, 1),
                           $urandom_range(0, 180), $urandom_range(0, 59),
                           $urandom_range(0, 59), $urandom_range(0, 1),
                           $urandom_range(0, 90), $urandom_range(0, 3599),
                           $urandom_range(0, 648000), $urandom_range(0, 3));
        else
            // anything the fields can hold; angles wrap
            it = gcd_pkg::in_item_t'(InBits'({$urandom(), $urandom(), $urandom()}));
        return it;
    endfunction

    function automatic int draw_gap();
        // runs of back-to-back items now and then
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Offer one item; valid stays high across back-to-back items.
    task automatic send_pair(gcd_pkg::in_item_t it, int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic send_directed();
        gcd_pkg::in_item_t list[$];
        list.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // same point
        list.push_back(make_pair(90, 0, 0, 0, 0, 0, 0, 0, 90, 0, 0, 1));        // pole to pole
        list.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 648000, 0));     // antipodal
        list.push_back(make_pair(0, 0, 0, 0, 180, 0, 0, 1, 0, 0, 648000, 0));   // 180 W = 180 E
        list.push_back(make_pair(90, 59, 59, 1, 180, 59, 59, 1, 90, 3599, 648000, 3));
        list.push_back(make_pair(127, 63, 63, 1, 255, 63, 63, 1, 127, 4095, 1048575, 3));
        list.push_back(make_pair(127, 63, 63, 0, 255, 63, 63, 0, 127, 4095, 1048575, 0));
        list.push_back(make_pair(45, 30, 30, 0, 90, 0, 0, 0, 45, 1830, 324000, 2));
        list.push_back(make_pair(45, 30, 30, 0, 90, 0, 0, 0, 45, 1831, 324000, 0)); // 1 arcsec
        list.push_back(make_pair(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        list.push_back(make_pair(89, 59, 59, 0, 0, 0, 0, 1, 89, 3599, 0, 1));
        list.push_back(make_pair(0, 0, 0, 1, 90, 0, 0, 1, 0, 0, 324000, 2));
        list.push_back(make_pair(60, 0, 0, 0, 120, 0, 0, 0, 60, 0, 432000, 3));
        list.push_back(make_pair(33, 51, 35, 1, 151, 12, 40, 0, 51, 1827, 447, 2));
        list.push_back(make_pair(90, 0, 0, 1, 17, 0, 0, 0, 90, 0, 123456, 1)); // same pole
        list.push_back(make_pair(0, 0, 0, 0, 179, 59, 59, 0, 0, 0, 648000, 2));
        foreach (list[i])
            send_pair(list[i], draw_gap());
    endtask

    // Receiver: random stall before each result, plus one long hold-off.
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (hold_output)
                gap = 400;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    initial
    begin
        board = new();
        foreach (arctan_tab[i])
            arctan_tab[i] = arctan_step(i);
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        for (int n = 0; n < ItemCount; n++)
        begin
            // a long receiver stall fills the pipe while items keep coming
            hold_output = (n >= 600 && n < 610);
            if (n >= 600 && n < 900)
                send_pair(random_pair(), 0);
            else
                send_pair(random_pair(), draw_gap());
        end
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (board.errors == 0)
            $display("great_circle_distance_tb OK");
        else
            $display("great_circle_distance_tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_if.sv
rtl/gcd_trig.sv
rtl/gcd_merge.sv
rtl/great_circle_distance.sv
rtl/gcd_checker.sv
tb/sv/great_circle_distance_tb.sv
